>>> rtl/core/stun_binding_response_builder_defines.svh
// assertion macros shared by the stun response builder rtl
`ifndef STUN_BINDING_RESPONSE_BUILDER_DEFINES_SVH
`define STUN_BINDING_RESPONSE_BUILDER_DEFINES_SVH
// clocked implication check, disabled while reset is high
`define SBRB_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication check
`define SBRB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

>>> rtl/core/sbrb_pkg.sv
// shared types, constants and functions of the stun response builder
`default_nettype none
package sbrb_pkg;
   localparam int KEY_BYTES_MAX = 48;
   localparam int KEY_REGS = KEY_BYTES_MAX / 8;
   localparam logic [31:0] COOKIE = 32'h2112A442;
   localparam logic [15:0] PORT_XOR = 16'h2112;
   localparam logic [31:0] FP_XOR = 32'h5354554E;
   localparam logic [31:0] CRC_POLY = 32'hEDB88320;
   localparam logic [2:0] CSR_KEY_LEN = 3'(KEY_REGS);
   localparam logic [159:0] SHA1_IV = 160'h67452301EFCDAB8998BADCFE10325476C3D2E1F0;

   typedef struct packed {
      logic [31:0] transaction_id_high;
      logic [63:0] transaction_id_low;
      logic [31:0] mapped_address;
      logic [15:0] peer_port;
   } req_type;

   typedef struct packed {
      logic [63:0] response_word;
      logic [2:0]  word_index;
      logic        last_word;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_LOAD, ST_ROUND, ST_FOLD, ST_CRC, ST_OUT
   } state_type;

   // control from sequencer to the sha-1 round unit
   typedef struct packed {
      logic       init;   // load chaining value with sha-1 iv
      logic       start;  // load working vars from chaining value, or from the iv with init
      logic       round;  // one round
      logic       fold;   // add working vars into chaining value
      logic [6:0] rnd;    // round number
   } sha_ctl_type;

   function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
      rotl = (v << n) | (v >> (32 - n));
   endfunction
endpackage
`default_nettype wire

>>> rtl/core/sbrb_sha1.sv
// sha-1 compression unit: one round per cycle while ctl.round is set, over a 16-word schedule window
`default_nettype none
module sbrb_sha1 (
   input  wire logic                 clock,
   input  wire sbrb_pkg::sha_ctl_type ctl,
   input  wire logic [511:0]         block_in,
   output logic [159:0]              digest
);
   logic [159:0] h_ff, h_in;
   logic [31:0] a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [31:0] a_in, b_in, c_in, d_in, e_in;
   logic [511:0] w_ff, w_in;
   logic [31:0] f, k, wt, wnew;

   always_comb begin
      wt = w_ff[511:480];
      wnew = sbrb_pkg::rotl(w_ff[95:64] ^ w_ff[255:224] ^ w_ff[447:416] ^ w_ff[511:480], 1);
      priority if (ctl.rnd < 7'd20) begin
         f = (b_ff & c_ff) | (~b_ff & d_ff); k = 32'h5A827999;
      end else if (ctl.rnd < 7'd40) begin
         f = b_ff ^ c_ff ^ d_ff; k = 32'h6ED9EBA1;
      end else if (ctl.rnd < 7'd60) begin
         f = (b_ff & c_ff) | (b_ff & d_ff) | (c_ff & d_ff); k = 32'h8F1BBCDC;
      end else begin
         f = b_ff ^ c_ff ^ d_ff; k = 32'hCA62C1D6;
      end
      h_in = h_ff; a_in = a_ff; b_in = b_ff; c_in = c_ff; d_in = d_ff; e_in = e_ff;
      w_in = w_ff;
      if (ctl.init)
         h_in = sbrb_pkg::SHA1_IV;
      if (ctl.start) begin
         {a_in, b_in, c_in, d_in, e_in} = ctl.init ? sbrb_pkg::SHA1_IV : h_ff;
         w_in = block_in;
      end
      if (ctl.round) begin
         a_in = sbrb_pkg::rotl(a_ff, 5) + f + e_ff + k + wt;
         b_in = a_ff; c_in = sbrb_pkg::rotl(b_ff, 30); d_in = c_ff; e_in = d_ff;
         w_in = {w_ff[479:0], wnew};
      end
      if (ctl.fold)
         h_in = {h_ff[159:128] + a_ff, h_ff[127:96] + b_ff, h_ff[95:64] + c_ff,
                 h_ff[63:32] + d_ff, h_ff[31:0] + e_ff};
   end

   always_ff @(posedge clock) begin
      h_ff <= h_in; w_ff <= w_in;
      a_ff <= a_in; b_ff <= b_in; c_ff <= c_in; d_ff <= d_in; e_ff <= e_in;
   end

   assign digest = h_ff;
endmodule
`default_nettype wire

>>> rtl/core/stun_binding_response_builder.sv
// top level: stun binding success response builder with hmac-sha1 and crc-32
//
//  channel | dir | handshake          | payload
//  req     | in  | req_valid/ready    | sbrb_pkg::req_type
//  rsp     | out | rsp_valid/ready    | sbrb_pkg::rsp_type, eight beats per request
//  csr     | in  | csr_write          | csr_index, csr_wdata
//
// one request takes four sha-1 passes (load, 80 rounds, fold each), then a bit-serial
// crc over 448 bits and eight output beats
// reset clears the sequencer and the key registers
// a stalled rsp beat holds until taken; no request is taken until the last beat is gone
`default_nettype none
`include "stun_binding_response_builder_defines.svh"
module stun_binding_response_builder (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire sbrb_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output sbrb_pkg::rsp_type     rsp_data,
   input  wire logic             csr_write,
   input  wire logic [2:0]       csr_index,
   input  wire logic [63:0]      csr_wdata
);
   // key store
   logic [63:0] key_ff [sbrb_pkg::KEY_REGS];
   logic [5:0]  klen_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < sbrb_pkg::KEY_REGS; i++) key_ff[i] <= '0;
         klen_ff <= '0;
      end else if (csr_write) begin
         if (csr_index < 3'(sbrb_pkg::KEY_REGS)) key_ff[csr_index] <= csr_wdata;
         else if (csr_index == sbrb_pkg::CSR_KEY_LEN) klen_ff <= csr_wdata[5:0];
      end
   end

   // zero-padded 64-byte key, bytes at or past the saturated length cleared
   logic [511:0] key_blk;
   logic [sbrb_pkg::KEY_REGS*64-1:0] key_cat;
   logic [5:0]   klen_eff;
   always_comb begin
      klen_eff = (klen_ff > 6'(sbrb_pkg::KEY_BYTES_MAX)) ? 6'(sbrb_pkg::KEY_BYTES_MAX) : klen_ff;
      for (int j = 0; j < sbrb_pkg::KEY_REGS; j++)
         key_cat[sbrb_pkg::KEY_REGS*64 - 1 - 64*j -: 64] = key_ff[j];
      key_blk = '0;
      for (int i = 0; i < sbrb_pkg::KEY_BYTES_MAX; i++)
         if (6'(i) < klen_eff)
            key_blk[511 - 8*i -: 8] = key_cat[sbrb_pkg::KEY_REGS*64 - 1 - 8*i -: 8];
   end

   // response buffer, bytes 0..63 from msb
   logic [511:0] r_ff, r_in;
   sbrb_pkg::state_type state_ff, state_in;
   logic [1:0] phase_ff, phase_in;   // which of the four compressions
   logic [6:0] rnd_ff, rnd_in;
   logic [8:0] bit_ff, bit_in;       // crc bit counter
   logic [8:0] crc_pos;              // buffer bit under the crc, lsb of each byte first
   logic [31:0] crc_ff, crc_in;
   logic [2:0] widx_ff, widx_in;
   logic [8:0] word_msb;
   logic [159:0] inner_ff, inner_in;
   sbrb_pkg::sha_ctl_type ctl;
   logic [511:0] sha_blk;
   logic [159:0] digest;
   logic rsp_last_beat;

   sbrb_sha1 u_sha (.clock(clock), .ctl(ctl), .block_in(sha_blk), .digest(digest));

   always_comb begin
      unique case (phase_ff)
         2'd0: sha_blk = key_blk ^ {64{8'h36}};
         2'd1: sha_blk = {r_ff[511:256], 8'h80, 216'h0, 32'd768};
         2'd2: sha_blk = key_blk ^ {64{8'h5C}};
         default: sha_blk = {inner_ff, 8'h80, 312'h0, 32'd672};
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sbrb_pkg::ST_IDLE:  if (req_valid) state_in = sbrb_pkg::ST_LOAD;
         sbrb_pkg::ST_LOAD:  state_in = sbrb_pkg::ST_ROUND;
         sbrb_pkg::ST_ROUND: if (rnd_ff == 7'd79) state_in = sbrb_pkg::ST_FOLD;
         sbrb_pkg::ST_FOLD:  state_in = (phase_ff == 2'd3) ? sbrb_pkg::ST_CRC : sbrb_pkg::ST_LOAD;
         sbrb_pkg::ST_CRC:   if (bit_ff == 9'd447) state_in = sbrb_pkg::ST_OUT;
         sbrb_pkg::ST_OUT:   if (rsp_ready && widx_ff == 3'd7) state_in = sbrb_pkg::ST_IDLE;
         default:            state_in = sbrb_pkg::ST_IDLE;
      endcase
   end

   // outputs and datapath control
   always_comb begin
      ctl = '0;
      ctl.rnd = rnd_ff;
      r_in = r_ff; phase_in = phase_ff; rnd_in = rnd_ff; bit_in = bit_ff;
      crc_in = crc_ff; widx_in = widx_ff; inner_in = inner_ff;
      req_ready = 1'b0; rsp_valid = 1'b0;
      crc_pos = 9'd504 - {bit_ff[8:3], 3'b000} + {6'd0, bit_ff[2:0]};
      unique case (state_ff)
         sbrb_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            phase_in = '0; widx_in = '0; bit_in = '0; crc_in = '1;
            // header length 36 for the mac pass
            r_in = {16'h0101, 16'd36, sbrb_pkg::COOKIE, req_data.transaction_id_high,
                    req_data.transaction_id_low, 32'h00200008, 16'h0001,
                    req_data.peer_port ^ sbrb_pkg::PORT_XOR,
                    req_data.mapped_address ^ sbrb_pkg::COOKIE, 256'h0};
         end
         sbrb_pkg::ST_LOAD: begin
            // inner and outer hash each start from the iv
            ctl.init = ~phase_ff[0];
            ctl.start = 1'b1; rnd_in = '0;
            // inner digest still sits in the chaining value here
            if (phase_ff == 2'd2) inner_in = digest;
         end
         sbrb_pkg::ST_ROUND: begin
            ctl.round = 1'b1; rnd_in = rnd_ff + 7'd1;
         end
         sbrb_pkg::ST_FOLD: begin
            ctl.fold = 1'b1;
            phase_in = phase_ff + 2'd1;
         end
         sbrb_pkg::ST_CRC: begin
            // mac attribute and final length go in before the crc reaches them
            if (bit_ff == 9'd0) begin
               r_in[487:480] = 8'd44;
               r_in[255:224] = 32'h00080014;
               r_in[223:64] = digest;
            end
            crc_in = (crc_ff >> 1) ^
                     (((crc_ff[0] ^ r_ff[crc_pos]) == 1'b1) ? sbrb_pkg::CRC_POLY : 32'h0);
            bit_in = bit_ff + 9'd1;
            if (bit_ff == 9'd447) begin
               r_in[31:0] = ~crc_in ^ sbrb_pkg::FP_XOR;
               r_in[63:32] = 32'h80280004;
            end
         end
         sbrb_pkg::ST_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) widx_in = widx_ff + 3'd1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sbrb_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      phase_ff <= phase_in; rnd_ff <= rnd_in; bit_ff <= bit_in; crc_ff <= crc_in;
      widx_ff <= widx_in;
      r_ff <= r_in; inner_ff <= inner_in;
   end

   // word k starts at bit 511 - 64k
   assign word_msb = {~widx_ff, 6'h3F};
   assign rsp_data.response_word = r_ff[word_msb -: 64];
   assign rsp_data.word_index = widx_ff;
   assign rsp_data.last_word = (widx_ff == 3'd7);
   assign rsp_last_beat = rsp_valid && rsp_ready && rsp_data.last_word;

   `SBRB_ASSERT_IMPL(a_no_overlap, clock, reset, rsp_valid, !req_ready, "ready while emitting")
   `SBRB_ASSERT_NEXT(a_last_ends, clock, reset, rsp_last_beat, req_ready, "no return to idle")
   `SBRB_ASSERT_IMPL(a_round_range, clock, reset, state_ff == sbrb_pkg::ST_ROUND, rnd_ff < 7'd80, "round overrun")
endmodule
`default_nettype wire
